@@ rtl/core/ihb_pkg.sv @@
// Shared types, constants and header field helpers for the IPv4 header builder.
package ihb_pkg;

  localparam int HEADER_WORDS = 10;
  localparam int HEADER_BYTES = 2 * HEADER_WORDS;
  localparam int IDX_W        = 5;
  localparam int ROT_W        = $clog2(HEADER_WORDS + 1);

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(HEADER_BYTES - 1);
  localparam logic [ROT_W-1:0] ROT_DONE   = ROT_W'(HEADER_WORDS);

  localparam logic [7:0] VER_IHL  = 8'h45;
  localparam logic [7:0] FLAG_DF  = 8'h40;
  localparam logic [7:0] FLAG_MF  = 8'h20;
  localparam logic [1:0] FSEL_DF  = 2'd1;
  localparam logic [1:0] FSEL_MF  = 2'd2;

  typedef struct packed {
    logic [7:0]  type_of_service;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [1:0]  flag_select;
    logic [15:0] offset_bytes;
    logic [7:0]  time_to_live;
    logic [7:0]  proto_number;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } hdr_in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_byte;
  } hdr_out_t;

  // per-row control for a chain of cells
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef logic [HEADER_WORDS-1:0][15:0] word_arr_t;

  function automatic logic [7:0] flag_byte(input logic [1:0] fsel);
    logic [7:0] f;
    case (fsel)
      FSEL_DF: f = FLAG_DF;
      FSEL_MF: f = FLAG_MF;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // header as 16-bit words, checksum word left zero
  function automatic word_arr_t build_words(input hdr_in_t h);
    word_arr_t  w;
    logic [12:0] frag;
    frag  = h.offset_bytes[15:3];
    w[0] = {VER_IHL, h.type_of_service};
    w[1] = h.total_length;
    w[2] = h.ident;
    w[3] = {flag_byte(h.flag_select) | {3'b000, frag[12:8]}, frag[7:0]};
    w[4] = {h.time_to_live, h.proto_number};
    w[5] = 16'h0000;
    w[6] = h.src_ip[31:16];
    w[7] = h.src_ip[15:0];
    w[8] = h.dst_ip[31:16];
    w[9] = h.dst_ip[15:0];
    return w;
  endfunction

endpackage

@@ rtl/core/ihb_cell.sv @@
// One storage cell of a shift chain: parallel load or take the neighbor's value.
module ihb_cell #(
  parameter int W = 8
) (
  input  logic              clk,
  input  ihb_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]      load_val,
  input  logic [W-1:0]      shift_in,
  output logic [W-1:0]      q
);
  import ihb_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_val;
    end else if (ctl.shift) begin
      q <= shift_in;
    end
  end

endmodule

@@ rtl/core/ihb_csum.sv @@
// One's-complement accumulator fed one header word per cycle while shift is high.
module ihb_csum (
  input  logic              clk,
  input  ihb_pkg::cell_ctl_t ctl,
  input  logic [15:0]       word,
  output logic [15:0]       sum
);
  import ihb_pkg::*;

  logic [16:0] raw;
  logic [15:0] sum_next;

  // end-around carry; raw[15:0] cannot be 0xFFFF when the carry is set
  assign raw      = {1'b0, sum} + {1'b0, word};
  assign sum_next = raw[15:0] + {15'd0, raw[16]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum <= 16'h0000;
    end else if (ctl.shift) begin
      sum <= sum_next;
    end
  end

endmodule

@@ rtl/core/ipv4_header_builder_core.sv @@
// IPv4 header builder: word ring with checksum accumulator feeding a byte output chain.
//
//  channel   | signals               | handshake
//  ----------+-----------------------+-----------------------------------------
//  request   | start, busy, header   | transaction taken when start && !busy
//  result    | strobe, result        | one byte per cycle while strobe is high
//
//  A request loads a ring of ten word cells; the ring rotates once while the
//  checksum accumulates, then the byte chain is loaded and the first byte shows
//  on result. All twenty bytes follow back to back. The next request is taken
//  while bytes still stream; sustained rate is set by the output chain shifting
//  one byte cell a cycle. Synchronous reset clears all control state.
//  The receiver cannot stall.
module ipv4_header_builder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ihb_pkg::hdr_in_t  header,
  output logic              busy,
  output logic              strobe,
  output ihb_pkg::hdr_out_t result
);
  import ihb_pkg::*;

  logic             pend_v;
  logic [ROT_W-1:0] rot_cnt;
  logic             emitting;
  logic [IDX_W-1:0] emit_cnt;

  logic       accept;
  logic       sum_run;
  logic       xfer;
  cell_ctl_t  ring_ctl;
  cell_ctl_t  chain_ctl;
  word_arr_t  ring_load;
  word_arr_t  ring;
  logic [15:0] csum;
  logic [15:0] csum_inv;
  logic [HEADER_BYTES-1:0][7:0] chain;

  assign accept   = start && !busy;
  assign sum_run  = pend_v && (rot_cnt != ROT_DONE);
  assign xfer     = pend_v && (rot_cnt == ROT_DONE) &&
                    (!emitting || (emit_cnt == LAST_INDEX));
  assign ring_ctl  = '{load: accept, shift: sum_run};
  assign chain_ctl = '{load: xfer, shift: emitting};
  assign ring_load = build_words(header);
  assign csum_inv  = ~csum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      rot_cnt  <= '0;
      emitting <= 1'b0;
      emit_cnt <= '0;
    end else begin
      if (accept) begin
        pend_v  <= 1'b1;
        rot_cnt <= '0;
      end else begin
        if (xfer) begin
          pend_v <= 1'b0;
        end
        if (sum_run) begin
          rot_cnt <= rot_cnt + ROT_W'(1);
        end
      end
      if (xfer) begin
        emitting <= 1'b1;
        emit_cnt <= '0;
      end else if (emitting) begin
        if (emit_cnt == LAST_INDEX) begin
          emitting <= 1'b0;
        end else begin
          emit_cnt <= emit_cnt + IDX_W'(1);
        end
      end
    end
  end

  // word ring: rotates toward word 0, back in place after a full turn
  for (genvar i = 0; i < HEADER_WORDS; i++) begin : g_ring
    ihb_cell #(.W(16)) u_word (
      .clk      (clk),
      .ctl      (ring_ctl),
      .load_val (ring_load[i]),
      .shift_in (ring[(i + 1) % HEADER_WORDS]),
      .q        (ring[i])
    );
  end

  ihb_csum u_csum (
    .clk  (clk),
    .ctl  (ring_ctl),
    .word (ring[0]),
    .sum  (csum)
  );

  // byte chain: cell 0 drives the result port
  for (genvar j = 0; j < HEADER_BYTES; j++) begin : g_chain
    logic [7:0] lv;
    logic [7:0] si;
    if (j == 10) begin : g_ck_hi
      assign lv = csum_inv[15:8];
    end else if (j == 11) begin : g_ck_lo
      assign lv = csum_inv[7:0];
    end else begin : g_plain
      assign lv = ring[j / 2][15 - 8 * (j % 2) -: 8];
    end
    if (j == HEADER_BYTES - 1) begin : g_tail
      assign si = 8'h00;
    end else begin : g_body
      assign si = chain[j + 1];
    end
    ihb_cell #(.W(8)) u_byte (
      .clk      (clk),
      .ctl      (chain_ctl),
      .load_val (lv),
      .shift_in (si),
      .q        (chain[j])
    );
  end

  assign busy              = pend_v;
  assign strobe            = emitting;
  assign result.out_byte   = chain[0];
  assign result.byte_index = emit_cnt;
  assign result.last_byte  = (emit_cnt == LAST_INDEX);

  // a header streams without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_byte |=>
      strobe && (result.byte_index == $past(result.byte_index) + IDX_W'(1)))
    else $error("gap or skipped index in header stream");

  // every header opens with version 4, IHL 5
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.byte_index == '0) |-> result.out_byte == VER_IHL)
    else $error("first header byte is not 0x45");

  // a taken request is captured: busy is set and the rotation count restarts from zero
  a_hold: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && (rot_cnt == '0))
    else $error("request not captured");

  // the chain is reloaded only after a full ring turn; it may wait on the chain
  a_xfer: assert property (@(posedge clk) disable iff (rst)
    xfer |-> $past(pend_v) && ($past(sum_run) || ($past(rot_cnt) == ROT_DONE)))
    else $error("transfer before checksum complete");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the IPv4 header builder: directed table, then random headers.
`timescale 1ns / 100ps

module tb_top;
  import ihb_pkg::*;

  localparam int RANDOM_HEADERS = 416;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int NUM_DIRECTED   = 14;

  typedef struct packed {
    hdr_in_t     hdr;
    logic        pinned;   // checksum typed in below, not predicted
    logic [15:0] csum;
  } hdr_vec_t;

  logic     clk;
  logic     rst;
  logic     start;
  hdr_in_t  header;
  logic     busy;
  logic     strobe;
  hdr_out_t result;

  hdr_out_t pending_bytes[$];
  hdr_vec_t directed[NUM_DIRECTED];
  int       mismatches;
  int       cycle_count;
  bit       idle_on;

  ipv4_header_builder_core DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .header (header),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Builds the 20 header bytes with their checksum and queues them in send order.
  function automatic void queue_header(input hdr_in_t h, input bit pinned,
                                       input logic [15:0] pinned_csum);
    logic [7:0]  hb [0:HEADER_BYTES-1];
    logic [12:0] frag;
    logic [7:0]  flags;
    logic [31:0] acc;
    logic [15:0] csum;
    hdr_out_t    r;
    frag = 13'(h.offset_bytes / 16'd8);
    case (h.flag_select)
      FSEL_DF: flags = FLAG_DF;
      FSEL_MF: flags = FLAG_MF;
      default: flags = 8'h00;
    endcase
    hb[0]  = VER_IHL;
    hb[1]  = h.type_of_service;
    hb[2]  = h.total_length[15:8];
    hb[3]  = h.total_length[7:0];
    hb[4]  = h.ident[15:8];
    hb[5]  = h.ident[7:0];
    hb[6]  = flags | {3'b000, frag[12:8]};
    hb[7]  = frag[7:0];
    hb[8]  = h.time_to_live;
    hb[9]  = h.proto_number;
    hb[10] = 8'h00;
    hb[11] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      hb[12+k] = h.src_ip[31-8*k -: 8];
      hb[16+k] = h.dst_ip[31-8*k -: 8];
    end
    acc = '0;
    for (int w = 0; w < HEADER_WORDS; w++) acc += {16'h0000, hb[2*w], hb[2*w+1]};
    while (acc[31:16] != 0) acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
    csum   = pinned ? pinned_csum : ~acc[15:0];
    hb[10] = csum[15:8];
    hb[11] = csum[7:0];
    for (int i = 0; i < HEADER_BYTES; i++) begin
      r.out_byte   = hb[i];
      r.byte_index = IDX_W'(i);
      r.last_byte  = (i == HEADER_BYTES - 1);
      pending_bytes.push_back(r);
    end
  endfunction

  function automatic logic [31:0] pick_val(input logic [31:0] max_val);
    case ($urandom_range(7))
      0:       return '0;
      1:       return max_val;
      default: return $urandom() & max_val;
    endcase
  endfunction

  function automatic hdr_in_t rand_header();
    hdr_in_t h;
    h.type_of_service = 8'(pick_val(32'hFF));
    h.total_length    = 16'(pick_val(32'hFFFF));
    h.ident           = 16'(pick_val(32'hFFFF));
    h.flag_select     = 2'($urandom_range(3));
    h.offset_bytes    = 16'(pick_val(32'hFFFF));
    h.time_to_live    = 8'(pick_val(32'hFF));
    h.proto_number    = 8'(pick_val(32'hFF));
    h.src_ip          = pick_val(32'hFFFF_FFFF);
    h.dst_ip          = pick_val(32'hFFFF_FFFF);
    return h;
  endfunction

  function automatic hdr_in_t mk(input logic [7:0] tos, input logic [15:0] len,
                                 input logic [15:0] id, input logic [1:0] fsel,
                                 input logic [15:0] off, input logic [7:0] ttl,
                                 input logic [7:0] proto, input logic [31:0] src,
                                 input logic [31:0] dst);
    return '{tos, len, id, fsel, off, ttl, proto, src, dst};
  endfunction

  // Entered and left at a falling edge; start stays high across back-to-back transactions.
  task automatic issue_header(input hdr_in_t h, input bit pinned, input logic [15:0] csum);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 36)
      gap = ($urandom_range(3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    header <= h;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    queue_header(h, pinned, csum);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[ipv4_header_builder_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    hdr_out_t want;
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h at index %0d",
                                  result.out_byte, result.byte_index));
      end else begin
        want = pending_bytes.pop_front();
        if (result.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte idx %0d: got %h want %h",
                                    want.byte_index, result.out_byte, want.out_byte));
        if (result.byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index: got %0d want %0d",
                                    result.byte_index, want.byte_index));
        if (result.last_byte !== want.last_byte)
          report_mismatch($sformatf("last_byte idx %0d: got %b want %b",
                                    want.byte_index, result.last_byte, want.last_byte));
      end
    end
  end

  initial begin
    mismatches  = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    rst         = 1'b1;
    start       = 1'b0;
    header      = '0;

    // all-zero header sums to 0x4500; checksum 0xFFFF-style words fold away
    directed[0]  = '{mk(8'h00, 16'h0000, 16'h0000, 2'd0, 16'h0000, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'hBAFF};
    directed[1]  = '{mk(8'hFF, 16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 8'hFF, 8'hFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, 16'h9A01};
    directed[2]  = '{mk(8'h00, 16'h0000, 16'h0000, FSEL_DF, 16'h0000, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'h7AFF};
    directed[3]  = '{mk(8'h00, 16'h0000, 16'h0000, FSEL_MF, 16'h0000, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'h9AFF};
    directed[4]  = '{mk(8'h00, 16'h0000, 16'h0000, 2'd3, 16'h0000, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'hBAFF};
    // offset truncation: 7 bytes rounds down to zero, 8 bytes is one unit
    directed[5]  = '{mk(8'h00, 16'h0000, 16'h0000, 2'd0, 16'd7, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'hBAFF};
    directed[6]  = '{mk(8'h00, 16'h0000, 16'h0000, 2'd0, 16'd8, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'hBAFE};
    directed[7]  = '{mk(8'h00, 16'h0000, 16'h0000, FSEL_DF, 16'hFFFF, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'h5B00};
    // end-around carries
    directed[8]  = '{mk(8'h00, 16'h0000, 16'h0000, 2'd0, 16'h0000, 8'h00, 8'h00,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, 16'hBAFF};
    // sum lands on 0xFFFF, checksum comes out zero
    directed[9]  = '{mk(8'h00, 16'hBAFF, 16'h0000, 2'd0, 16'h0000, 8'h00, 8'h00,
                        32'h0, 32'h0), 1'b1, 16'h0000};
    directed[10] = '{mk(8'h00, 16'h003C, 16'h1C46, FSEL_DF, 16'h0000, 8'h40, 8'h06,
                        32'hAC10_000A, 32'hAC10_0063), 1'b0, 16'h0000};
    directed[11] = '{mk(8'hB8, 16'd1500, 16'hABCD, FSEL_MF, 16'd1480, 8'h01, 8'h11,
                        32'hC0A8_0001, 32'h0808_0808), 1'b0, 16'h0000};
    directed[12] = '{mk(8'h55, 16'hAAAA, 16'h5555, FSEL_MF, 16'hAAAA, 8'hAA, 8'h55,
                        32'h55AA_55AA, 32'hAA55_AA55), 1'b0, 16'h0000};
    directed[13] = '{mk(8'hAA, 16'h5555, 16'hAAAA, FSEL_DF, 16'h5555, 8'h55, 8'hAA,
                        32'hAA55_AA55, 32'h55AA_55AA), 1'b0, 16'h0000};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      issue_header(directed[i].hdr, directed[i].pinned, directed[i].csum);

    for (int i = 0; i < RANDOM_HEADERS; i++) begin
      idle_on = !(i >= 100 && i < 180);   // back-to-back stretch
      if (i == 250) begin
        // hold off until the pipe has fully drained
        start <= 1'b0;
        @(negedge clk);
        while (pending_bytes.size() != 0) @(negedge clk);
      end
      issue_header(rand_header(), 1'b0, 16'h0000);
    end

    start <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("[ipv4_header_builder_core] OK");
    end else begin
      $display("[ipv4_header_builder_core] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ihb_pkg.sv
rtl/core/ihb_cell.sv
rtl/core/ihb_csum.sv
rtl/core/ipv4_header_builder_core.sv
tb/sv/tb_top.sv
